// ===== hdl/pfu_pkg.sv =====
// ----------------------------------------------------------------------------
// pfu_pkg
// Shared constants, codes and types of the pixel filter unit.
// ----------------------------------------------------------------------------
package pfu_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LANES_DEF       = 3;

    // fixed field widths
    localparam int PIXEL_BITS     = 48;
    localparam int WINDOW_PIXELS  = 6;
    localparam int IN_TDATA_BITS  = WINDOW_PIXELS * PIXEL_BITS;
    localparam int IN_TUSER_BITS  = 3;
    localparam int KIND_BITS      = 2;
    localparam int MAX_VALUE_BITS = 16;
    localparam int MASK_BITS      = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [MAX_VALUE_BITS-1:0] MAX_VALUE_RESET = 16'd255;

    // operation codes
    localparam logic [KIND_BITS-1:0] KIND_GRAY     = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_NEGATIVE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CONTOUR  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_BLUR     = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_VALUE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAY_MODE    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_MASK = 2'd2;

    // per-stage load strobes
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
    } pipe_ctrl_t;

endpackage

// ===== hdl/pfu_lane.sv =====
// ----------------------------------------------------------------------------
// pfu_lane
// One sample lane: negative, contour and five-tap blur over two stages.
// ----------------------------------------------------------------------------
module pfu_lane
    import pfu_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                      aclk,
    input  pipe_ctrl_t                ctrl,
    input  logic [KIND_BITS-1:0]      kind,
    input  logic [MAX_VALUE_BITS-1:0] max_value,
    input  logic [SAMPLE_BITS-1:0]    center,
    input  logic [SAMPLE_BITS-1:0]    left_far,
    input  logic [SAMPLE_BITS-1:0]    left_near,
    input  logic [SAMPLE_BITS-1:0]    right_near,
    input  logic [SAMPLE_BITS-1:0]    right_far,
    input  logic [SAMPLE_BITS-1:0]    below,
    output logic [SAMPLE_BITS-1:0]    lane_result
);

    localparam int SUM_BITS   = SAMPLE_BITS + 3;
    localparam int BLUR_SHIFT = SUM_BITS + 3;
    localparam int RECIP_BITS = BLUR_SHIFT;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam int CMP_BITS   = MAX_VALUE_BITS + 1;
    // ceil(2^shift / 5), exact for every sum below 2^SUM_BITS
    localparam logic [RECIP_BITS-1:0] BLUR_RECIP =
        RECIP_BITS'(((64'd1 << BLUR_SHIFT) + 64'd4) / 64'd5);
    localparam logic [CMP_BITS-1:0] LANE_MAX_EXT =
        CMP_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [SUM_BITS-1:0]    tap_sum;
    logic [CMP_BITS-1:0]    c_ext;
    logic [CMP_BITS-1:0]    mv_ext;
    logic [CMP_BITS-1:0]    neg_val;
    logic [SAMPLE_BITS-1:0] diff_below;
    logic [SAMPLE_BITS-1:0] diff_right;
    logic [CMP_BITS-1:0]    contour_sum;
    logic [CMP_BITS-1:0]    contour_val;
    logic [CMP_BITS-1:0]    point_pre;
    logic [CMP_BITS-1:0]    point_sat;
    logic [PROD_BITS-1:0]   blur_prod;
    logic [SAMPLE_BITS-1:0] blur_quot;

    logic [SUM_BITS-1:0]    sum_reg;
    logic [SAMPLE_BITS-1:0] point_reg;
    logic                   blur_reg;
    logic [SAMPLE_BITS-1:0] result_reg;

    always_comb begin
        tap_sum = SUM_BITS'(left_far) + SUM_BITS'(left_near) + SUM_BITS'(center)
                + SUM_BITS'(right_near) + SUM_BITS'(right_far);
        c_ext   = CMP_BITS'(center);
        mv_ext  = CMP_BITS'(max_value);
        neg_val = (c_ext > mv_ext) ? '0 : mv_ext - c_ext;
        diff_below  = (below >= center) ? below - center : center - below;
        diff_right  = (right_near >= center) ? right_near - center : center - right_near;
        contour_sum = CMP_BITS'(diff_below) + CMP_BITS'(diff_right);
        contour_val = (contour_sum > mv_ext) ? mv_ext : contour_sum;
        point_pre   = (kind == KIND_NEGATIVE) ? neg_val : contour_val;
        point_sat   = (point_pre > LANE_MAX_EXT) ? LANE_MAX_EXT : point_pre;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            sum_reg   <= tap_sum;
            point_reg <= point_sat[SAMPLE_BITS-1:0];
            blur_reg  <= (kind == KIND_BLUR);
        end
    end

    // divide by five through the reciprocal
    always_comb begin
        blur_prod = PROD_BITS'(sum_reg) * PROD_BITS'(BLUR_RECIP);
        blur_quot = blur_prod[BLUR_SHIFT +: SAMPLE_BITS];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load2) begin
            result_reg <= blur_reg ? blur_quot : point_reg;
        end
    end

    assign lane_result = result_reg;

endmodule

// ===== hdl/pfu_merge.sv =====
// ----------------------------------------------------------------------------
// pfu_merge
// Gray averaging path and the final lane merge into the output register.
// ----------------------------------------------------------------------------
module pfu_merge
    import pfu_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LANES       = LANES_DEF
) (
    input  logic                                aclk,
    input  pipe_ctrl_t                          ctrl,
    input  logic [KIND_BITS-1:0]                kind,
    input  logic                                on_border,
    input  logic [PIXEL_BITS-1:0]               center,
    input  logic                                gray_mode,
    input  logic [MASK_BITS-1:0]                channel_mask,
    input  logic [LANES-1:0][SAMPLE_BITS-1:0]   lane_results,
    output logic [PIXEL_BITS-1:0]               result_pixel
);

    localparam int GSUM_BITS   = SAMPLE_BITS + 2;
    localparam int GRAY_SHIFT  = GSUM_BITS + 2;
    localparam int GRECIP_BITS = GRAY_SHIFT + 1;
    localparam int GPROD_BITS  = GSUM_BITS + GRECIP_BITS;
    localparam logic [GRECIP_BITS-1:0] GRAY_RECIP =
        GRECIP_BITS'(((64'd1 << GRAY_SHIFT) + 64'(LANES) - 64'd1) / 64'(LANES));

    logic [GSUM_BITS-1:0]   gray_sum;
    logic [GPROD_BITS-1:0]  gray_prod;
    logic [MASK_BITS-1:0]   sel;
    logic [PIXEL_BITS-1:0]  result_next;

    logic [GSUM_BITS-1:0]   gsum_reg;
    logic [KIND_BITS-1:0]   kind1_reg;
    logic                   border1_reg;
    logic [PIXEL_BITS-1:0]  center1_reg;
    logic [SAMPLE_BITS-1:0] gray_q_reg;
    logic [KIND_BITS-1:0]   kind2_reg;
    logic                   border2_reg;
    logic [PIXEL_BITS-1:0]  center2_reg;
    logic [PIXEL_BITS-1:0]  result_reg;

    always_comb begin
        gray_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            gray_sum = gray_sum + GSUM_BITS'(center[i*SAMPLE_BITS +: SAMPLE_BITS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load1) begin
            gsum_reg    <= gray_sum;
            kind1_reg   <= kind;
            border1_reg <= on_border;
            center1_reg <= center;
        end
    end

    assign gray_prod = GPROD_BITS'(gsum_reg) * GPROD_BITS'(GRAY_RECIP);

    always_ff @(posedge aclk) begin
        if (ctrl.load2) begin
            gray_q_reg  <= gray_prod[GRAY_SHIFT +: SAMPLE_BITS];
            kind2_reg   <= kind1_reg;
            border2_reg <= border1_reg;
            center2_reg <= center1_reg;
        end
    end

    always_comb begin
        sel         = (channel_mask == '0) ? '1 : channel_mask;
        result_next = '0;
        if (border2_reg) begin
            result_next = center2_reg;
        end else if (kind2_reg == KIND_GRAY) begin
            result_next[SAMPLE_BITS-1:0] = gray_mode ? center2_reg[SAMPLE_BITS-1:0]
                                                     : gray_q_reg;
        end else if (gray_mode) begin
            result_next[SAMPLE_BITS-1:0] = lane_results[0];
        end else begin
            // unselected lanes pass the center sample through
            for (int i = 0; i < LANES; i++) begin
                result_next[i*SAMPLE_BITS +: SAMPLE_BITS] =
                    sel[i] ? lane_results[i] : center2_reg[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load3) begin
            result_reg <= result_next;
        end
    end

    assign result_pixel = result_reg;

endmodule

// ===== hdl/pixel_filter_unit.sv =====
// an accepted input moves through v1_reg, v2_reg and v3_reg, which drives m_tvalid;
// the blur and gray reciprocal multipliers sit in their own stage
// throughput: one item per cycle unless m_tready stalls; a stage refills once the next moves
// reset: synchronous, active low; clears the stage valid flags and loads
// max_value 255, gray_mode 0 and channel_mask 0
// ----------------------------------------------------------------------------
// pixel_filter_unit
// Per-pixel gray, negative, contour and horizontal blur with parallel lanes.
// ----------------------------------------------------------------------------
module pixel_filter_unit
    import pfu_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LANES       = LANES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // center, left_far, left_near, right_near, right_far, below (48 bits each)
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    // kind [1:0], on_border [2]
    input  logic [IN_TUSER_BITS-1:0]  s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // result_pixel
    output logic [PIXEL_BITS-1:0]     m_tdata,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wr_data
);

    logic [MAX_VALUE_BITS-1:0] max_value_reg;
    logic                      gray_mode_reg;
    logic [MASK_BITS-1:0]      channel_mask_reg;

    logic       v1_reg, v2_reg, v3_reg;
    logic       v1_next, v2_next, v3_next;
    pipe_ctrl_t ctrl;

    logic [KIND_BITS-1:0]              kind;
    logic                              on_border;
    logic [WINDOW_PIXELS-1:0][PIXEL_BITS-1:0] window;
    logic [LANES-1:0][SAMPLE_BITS-1:0] lane_results;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_value_reg    <= MAX_VALUE_RESET;
            gray_mode_reg    <= 1'b0;
            channel_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_VALUE:    max_value_reg    <= cfg_wr_data[MAX_VALUE_BITS-1:0];
                REG_GRAY_MODE:    gray_mode_reg    <= cfg_wr_data[0];
                REG_CHANNEL_MASK: channel_mask_reg <= cfg_wr_data[MASK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its successor loads
    always_comb begin
        ctrl.load3 = !v3_reg || m_tready;
        ctrl.load2 = !v2_reg || ctrl.load3;
        ctrl.load1 = !v1_reg || ctrl.load2;
        v1_next = ctrl.load1 ? s_tvalid : v1_reg;
        v2_next = ctrl.load2 ? v1_reg   : v2_reg;
        v3_next = ctrl.load3 ? v2_reg   : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign s_tready  = ctrl.load1;
    assign m_tvalid  = v3_reg;
    assign kind      = s_tuser[KIND_BITS-1:0];
    assign on_border = s_tuser[KIND_BITS];
    assign window    = s_tdata;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        pfu_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .kind        (kind),
            .max_value   (max_value_reg),
            .center      (window[0][g*SAMPLE_BITS +: SAMPLE_BITS]),
            .left_far    (window[1][g*SAMPLE_BITS +: SAMPLE_BITS]),
            .left_near   (window[2][g*SAMPLE_BITS +: SAMPLE_BITS]),
            .right_near  (window[3][g*SAMPLE_BITS +: SAMPLE_BITS]),
            .right_far   (window[4][g*SAMPLE_BITS +: SAMPLE_BITS]),
            .below       (window[5][g*SAMPLE_BITS +: SAMPLE_BITS]),
            .lane_result (lane_results[g])
        );
    end

    pfu_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LANES       (LANES)
    ) u_merge (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .kind         (kind),
        .on_border    (on_border),
        .center       (window[0]),
        .gray_mode    (gray_mode_reg),
        .channel_mask (channel_mask_reg),
        .lane_results (lane_results),
        .result_pixel (m_tdata)
    );

endmodule

// ===== hdl/pfu_checker.sv =====
// ----------------------------------------------------------------------------
// pfu_checker
// Port-level checks of the pixel filter unit, bound to the top level.
// ----------------------------------------------------------------------------
module pfu_checker
    import pfu_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [IN_TDATA_BITS-1:0]  s_tdata,
    input logic [IN_TUSER_BITS-1:0]  s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [PIXEL_BITS-1:0]     m_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // the input side never waits while the output drains or is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled although the pipeline can move");

    // border item reaches the output unchanged while m_tready stays high
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[KIND_BITS] && m_tready) ##1 m_tready ##1 m_tready
        |=> m_tvalid && (m_tdata == $past(s_tdata[PIXEL_BITS-1:0], 3)))
        else $error("border item not passed through");

endmodule

bind pixel_filter_unit pfu_checker u_pfu_checker (.*);
